>>> design/b2bcd_pkg.sv
// Shared constants and helpers for the binary-to-BCD converter.
// Depends on nothing; the converter top level imports it.
package b2bcd_pkg;

    // Fixed port widths of the converter.
    localparam int VALUE_W    = 20;
    localparam int DIGIT_W    = 4;
    localparam int OUT_DIGITS = 6;
    localparam int COUNT_W    = 3;

    // Defaults for the top-level parameters.
    localparam int DEF_INPUT_BITS    = 20;
    localparam int DEF_DIGIT_COLUMNS = 6;

    // Shift-and-add-3 steps folded into one pipeline stage.
    localparam int STEPS_PER_STAGE = 4;

    // Wide enough for ten decimal columns and for a 32-bit input.
    localparam int LIMIT_W = 40;

    // Internal digit count wide enough for ten columns.
    localparam int CNT_W = 4;

    // Double-dabble correction: a digit of five or more gets three added.
    localparam logic [DIGIT_W-1:0] ADD_THRESH = 4'd5;
    localparam logic [DIGIT_W-1:0] ADD_CORR   = 4'd3;
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = 4'd9;

    // Power of ten, evaluated at elaboration only.
    function automatic logic [LIMIT_W-1:0] pow10(input int n);
        logic [LIMIT_W-1:0] p;
        p = LIMIT_W'(1);
        for (int k = 0; k < n; k++) begin
            p = p * LIMIT_W'(10);
        end
        return p;
    endfunction

endpackage

>>> design/binary_to_bcd_converter.sv
// Pipelined binary-to-BCD converter (shift and add 3, double dabble).
// Depends on b2bcd_pkg for port widths, defaults and the power-of-ten helper.
//
// Usage: the input channel carries one unsigned binary word per handshake on
// i_value, qualified by i_valid; the converter pushes back with o_stall. A word
// is taken at a rising edge with i_valid high and o_stall low. The output
// channel carries six BCD digits, the number of significant digits (at least
// one) and a too-large flag, qualified by o_valid; the receiver pushes back
// with i_stall, and a word leaves at an edge with o_valid high and i_stall low.
//
// Each dabble stage folds four shift-and-add-3 steps over all digit columns,
// and one last stage forms the digit count and the saturation. Throughput is
// one word per cycle while the receiver does not stall the output.
//
// A value above 10^DIGIT_COLUMNS - 1 sets o_too_large, every kept digit reads
// nine and the count equals the number of columns (capped at six).
// Reset clears all stage valid bits; no word is in flight afterwards. When the
// receiver stalls a valid output word, the whole pipeline holds and o_stall
// is raised in the same cycle, so nothing is dropped or repeated.
module binary_to_bcd_converter #(
    parameter int INPUT_BITS    = b2bcd_pkg::DEF_INPUT_BITS,
    parameter int DIGIT_COLUMNS = b2bcd_pkg::DEF_DIGIT_COLUMNS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [b2bcd_pkg::VALUE_W-1:0]   i_value,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_hundred_thousands,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_ten_thousands,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_thousands,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_hundreds,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_tens,
    output logic [b2bcd_pkg::DIGIT_W-1:0]   o_digit_ones,
    output logic [b2bcd_pkg::COUNT_W-1:0]   o_digit_count,
    output logic                            o_too_large
);
    import b2bcd_pkg::*;

    // Number of dabble stages and width of the packed digit columns.
    localparam int NSTG   = (INPUT_BITS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int COLS_W = DIGIT_COLUMNS * DIGIT_W;
    localparam int OUT_W  = OUT_DIGITS * DIGIT_W;
    localparam logic [LIMIT_W-1:0] MAX_VAL = pow10(DIGIT_COLUMNS) - LIMIT_W'(1);
    localparam logic [CNT_W-1:0]   CNT_CAP = CNT_W'(OUT_DIGITS);
    localparam logic [CNT_W-1:0]   CNT_ALL = CNT_W'(DIGIT_COLUMNS);

    // One double-dabble step: correct every column, then shift one bit in.
    function automatic logic [COLS_W-1:0] dd_step(input logic [COLS_W-1:0] c,
                                                  input logic b);
        logic [COLS_W-1:0] a;
        a = c;
        for (int k = 0; k < DIGIT_COLUMNS; k++) begin
            if (a[k*DIGIT_W +: DIGIT_W] >= ADD_THRESH) begin
                a[k*DIGIT_W +: DIGIT_W] = a[k*DIGIT_W +: DIGIT_W] + ADD_CORR;
            end
        end
        return {a[COLS_W-2:0], b};
    endfunction

    // The pipeline moves unless a finished word is held by the receiver.
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Only the low INPUT_BITS bits of the port take part; extra bits are zero.
    logic [INPUT_BITS-1:0] v_in;
    for (genvar b = 0; b < INPUT_BITS; b++) begin : g_vin
        if (b < VALUE_W) begin : g_port
            assign v_in[b] = i_value[b];
        end else begin : g_zero
            assign v_in[b] = 1'b0;
        end
    end

    logic big_in;
    assign big_in = {{(LIMIT_W-INPUT_BITS){1'b0}}, v_in} > MAX_VAL;

    // Dabble stages: stage s holds the columns after (s+1)*4 steps (at most
    // INPUT_BITS) and the input bits still to be shifted in, left-aligned.
    logic [COLS_W-1:0]     r_col [NSTG];
    logic [COLS_W-1:0]     n_col [NSTG];
    logic [INPUT_BITS-1:0] r_val [NSTG];
    logic [INPUT_BITS-1:0] n_val [NSTG];
    logic [NSTG-1:0]       r_vld;
    logic [NSTG-1:0]       n_vld;
    logic [NSTG-1:0]       r_big;
    logic [NSTG-1:0]       n_big;

    for (genvar s = 0; s < NSTG; s++) begin : g_stage
        logic [COLS_W-1:0]     src_col;
        logic [INPUT_BITS-1:0] src_val;
        logic                  src_vld;
        logic                  src_big;

        if (s == 0) begin : g_first
            assign src_col = '0;
            assign src_val = v_in;
            assign src_vld = i_valid;
            assign src_big = big_in;
        end else begin : g_next
            assign src_col = r_col[s-1];
            assign src_val = r_val[s-1];
            assign src_vld = r_vld[s-1];
            assign src_big = r_big[s-1];
        end

        always_comb begin
            n_col[s] = src_col;
            for (int j = 0; j < STEPS_PER_STAGE; j++) begin
                if (s * STEPS_PER_STAGE + j < INPUT_BITS) begin
                    n_col[s] = dd_step(n_col[s], src_val[INPUT_BITS-1-j]);
                end
            end
            n_val[s] = src_val << STEPS_PER_STAGE;
            n_vld[s] = src_vld;
            n_big[s] = src_big;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (en) begin
                r_vld[s] <= n_vld[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_col[s] <= n_col[s];
                r_val[s] <= n_val[s];
                r_big[s] <= n_big[s];
            end
        end
    end

    // Output stage: saturation, digit count and mapping onto six fields.
    logic [COLS_W-1:0] col_sat;
    logic [CNT_W-1:0]  cnt;
    logic [OUT_W-1:0]  n_digits;
    logic [OUT_W-1:0]  r_digits;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_count;
    logic              r_big_o;
    logic              r_vld_o;

    always_comb begin
        cnt = CNT_W'(1);
        for (int c = 0; c < DIGIT_COLUMNS; c++) begin
            col_sat[c*DIGIT_W +: DIGIT_W] =
                r_big[NSTG-1] ? DIGIT_MAX : r_col[NSTG-1][c*DIGIT_W +: DIGIT_W];
            if (r_col[NSTG-1][c*DIGIT_W +: DIGIT_W] != '0) begin
                cnt = CNT_W'(c + 1);
            end
        end
        if (r_big[NSTG-1]) begin
            cnt = CNT_ALL;
        end
        if (cnt > CNT_CAP) begin
            cnt = CNT_CAP;
        end
        n_count = cnt[COUNT_W-1:0];
    end

    for (genvar d = 0; d < OUT_DIGITS; d++) begin : g_out
        if (d < DIGIT_COLUMNS) begin : g_kept
            assign n_digits[d*DIGIT_W +: DIGIT_W] = col_sat[d*DIGIT_W +: DIGIT_W];
        end else begin : g_blank
            assign n_digits[d*DIGIT_W +: DIGIT_W] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_o <= 1'b0;
        end else if (en) begin
            r_vld_o <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_digits <= n_digits;
            r_count  <= n_count;
            r_big_o  <= r_big[NSTG-1];
        end
    end

    assign o_valid                   = r_vld_o;
    assign o_digit_ones              = r_digits[0*DIGIT_W +: DIGIT_W];
    assign o_digit_tens              = r_digits[1*DIGIT_W +: DIGIT_W];
    assign o_digit_hundreds          = r_digits[2*DIGIT_W +: DIGIT_W];
    assign o_digit_thousands         = r_digits[3*DIGIT_W +: DIGIT_W];
    assign o_digit_ten_thousands     = r_digits[4*DIGIT_W +: DIGIT_W];
    assign o_digit_hundred_thousands = r_digits[5*DIGIT_W +: DIGIT_W];
    assign o_digit_count             = r_count;
    assign o_too_large               = r_big_o;

    // Every digit leaving the converter is a legal BCD digit.
    a_digits_bcd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_digit_ones <= DIGIT_MAX) && (o_digit_tens <= DIGIT_MAX) &&
                    (o_digit_hundreds <= DIGIT_MAX) && (o_digit_thousands <= DIGIT_MAX) &&
                    (o_digit_ten_thousands <= DIGIT_MAX) &&
                    (o_digit_hundred_thousands <= DIGIT_MAX))
        else $error("non-BCD digit on output");

    // A saturated word reports all kept columns as significant.
    a_big_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_large) |->
            (o_digit_count == ((CNT_ALL > CNT_CAP) ? CNT_CAP[COUNT_W-1:0]
                                                   : CNT_ALL[COUNT_W-1:0])))
        else $error("digit count wrong for saturated word");

    // While the receiver holds the output, no stage valid bit moves.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> ($stable(r_vld) && $stable(r_vld_o)))
        else $error("pipeline moved during output stall");

    // Reset leaves no word in flight.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_valid && (r_vld == '0)))
        else $error("word in flight after reset");

endmodule
